// ===== design/sacache_pkg.sv =====
// Shared constants for the set-associative tag cache model.
// Register indexes, reset values and fixed field widths; no dependencies.

package sacache_pkg;

    localparam int ADDR_IN_W = 32;
    localparam int TAG_W     = 32;
    localparam int CNT_W     = 32;
    localparam int OFF_W     = 4;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_SEL_W = 1;
    localparam int SHIFT_W   = 5;

    localparam logic [CFG_SEL_W-1:0] REG_OFFSET_BITS = 1'b0;
    localparam logic [CFG_SEL_W-1:0] REG_INDEX_BITS  = 1'b1;

    localparam logic [OFF_W-1:0] OFFSET_BITS_RST = 4'd6;
    localparam logic [IDX_W-1:0] INDEX_BITS_RST  = 3'd6;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

// ===== design/set_assoc_cache_fifo_tag_model.sv =====
// Set-associative read cache tag model with round-robin replacement.
// Depends on sacache_pkg for register indexes, reset values and widths.
//
// Usage:
//   s_* channel (valid/ready) carries one read byte address per item.
//   m_* channel (valid/ready) returns hit and the running hit and miss
//   counts (saturating at all ones) for each item, in order.
//   cfg_wr_en/cfg_index/cfg_wr_data write offset_bits (index 0) and
//   index_bits (index 1) while the block is idle; the user must see to that.
// Timing:
//   Two pipeline registers: the address register with the tag memory read,
//   then the result register. A result is valid once its item has passed
//   both. One item per cycle is sustained while m_ready is high; the rate is
//   set by the single read and single write port of each way's tag memory,
//   with a one-entry bypass for the miss fill written in the previous cycle.
// Reset:
//   aresetn clears all way valid bits, the counters and the pipeline;
//   victim pointers read as way 0 until their set takes its first fill.
//   No clearing pass is needed, items are accepted right after reset.
// Stall:
//   When m_ready is low with a result valid, the result and the lookup stage
//   hold, and s_ready drops once the lookup stage is occupied.

module set_assoc_cache_fifo_tag_model
    import sacache_pkg::*;
#(
    parameter int WAYS       = 4,
    parameter int SETS       = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_SEL_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADDR_IN_W-1:0] s_read_address,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [CNT_W-1:0]     m_hit_total,
    output logic [CNT_W-1:0]     m_miss_total
);

    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LIM       = $clog2(SETS + 1) - 1;
    localparam logic [IDX_W:0] LIM_V = (IDX_W + 1)'(LIM);
    localparam logic [63:0] AMASK64 = (64'd1 << ADDR_WIDTH) - 64'd1;
    localparam logic [ADDR_IN_W-1:0] ADDR_MASK = AMASK64[ADDR_IN_W-1:0];
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    logic [OFF_W-1:0] offset_bits_reg;
    logic [IDX_W-1:0] index_bits_reg;

    logic             s1_valid_reg;
    logic [SET_W-1:0] s1_set_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic             s1_fwd_reg;

    logic             byp_valid_reg;
    logic [SET_W-1:0] byp_set_reg;
    logic [WAY_W-1:0] byp_way_reg;
    logic [TAG_W-1:0] byp_tag_reg;
    logic [WAY_W-1:0] byp_ptr_reg;

    logic [TAG_W-1:0] tag_rd_reg [WAYS];
    logic [WAY_W-1:0] ptr_rd_reg;
    logic [WAY_W-1:0] ptr_mem [SETS];

    logic [WAYS-1:0]  valid_reg [SETS];

    logic             m_valid_reg;
    logic             m_hit_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;

    logic                 s_fire;
    logic                 s1_fire;
    logic [IDX_W-1:0]     ib;
    logic [SHIFT_W-1:0]   tag_shift;
    logic [ADDR_IN_W-1:0] addr_masked;
    logic [ADDR_IN_W-1:0] addr_shifted;
    logic [ADDR_IN_W-1:0] set_mask;
    logic [SET_W-1:0]     in_set;
    logic [TAG_W-1:0]     in_tag;
    logic                 byp_hit_set;
    logic [WAYS-1:0]      set_valid;
    logic                 hit;
    logic [WAY_W-1:0]     victim;
    logic [WAY_W-1:0]     victim_next;
    logic                 fill;

    assign ib = ({1'b0, index_bits_reg} > LIM_V) ? LIM_V[IDX_W-1:0] : index_bits_reg;
    assign tag_shift    = SHIFT_W'(offset_bits_reg) + SHIFT_W'(ib);
    assign addr_masked  = s_read_address & ADDR_MASK;
    assign addr_shifted = addr_masked >> offset_bits_reg;
    assign set_mask     = (ADDR_IN_W'(1) << ib) - ADDR_IN_W'(1);
    assign in_set       = SET_W'(addr_shifted & set_mask);
    assign in_tag       = TAG_W'(addr_masked >> tag_shift);

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    assign byp_hit_set = s1_fwd_reg && byp_valid_reg && (byp_set_reg == s1_set_reg);
    assign set_valid   = valid_reg[s1_set_reg];

    always_comb begin
        logic [TAG_W-1:0] way_tag;
        hit = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            way_tag = tag_rd_reg[w];
            if (byp_hit_set && (byp_way_reg == WAY_W'(w))) begin
                way_tag = byp_tag_reg;
            end
            if (set_valid[w] && (way_tag == s1_tag_reg)) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        if (!set_valid[0]) begin
            victim = '0;
        end else if (byp_hit_set) begin
            victim = byp_ptr_reg;
        end else begin
            victim = ptr_rd_reg;
        end
        victim_next = (victim >= LAST_WAY) ? '0 : victim + WAY_W'(1);
    end

    assign fill = s1_fire && !hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OFFSET_BITS: offset_bits_reg <= cfg_wr_data[OFF_W-1:0];
                REG_INDEX_BITS:  index_bits_reg  <= cfg_wr_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
            s1_fwd_reg   <= fill;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_set_reg <= in_set;
            s1_tag_reg <= in_tag;
        end
    end

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        logic [TAG_W-1:0] tag_mem [SETS];

        always_ff @(posedge aclk) begin
            if (fill && (victim == WAY_W'(w))) begin
                tag_mem[s1_set_reg] <= s1_tag_reg;
            end
            if (s_fire) begin
                tag_rd_reg[w] <= tag_mem[in_set];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fill) begin
            ptr_mem[s1_set_reg] <= victim_next;
        end
        if (s_fire) begin
            ptr_rd_reg <= ptr_mem[in_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (fill) begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fill) begin
            byp_set_reg <= s1_set_reg;
            byp_way_reg <= victim;
            byp_tag_reg <= s1_tag_reg;
            byp_ptr_reg <= victim_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SETS; s++) begin
                valid_reg[s] <= '0;
            end
        end else if (fill) begin
            valid_reg[s1_set_reg][victim] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            m_hit_reg    <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
                m_hit_reg   <= hit;
                if (hit && (hit_cnt_reg != CNT_MAX)) begin
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                end
                if (!hit && (miss_cnt_reg != CNT_MAX)) begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_hit_total  = hit_cnt_reg;
    assign m_miss_total = miss_cnt_reg;

endmodule

// ===== test/set_assoc_cache_fifo_tag_model_test.sv =====
`timescale 1ns / 1ps
// Testbench for set_assoc_cache_fifo_tag_model: a directed table, then random address streams
// under several offset/index splits, checked vs typed rows or a behavioral cache predictor.
// Depends on sacache_pkg and the set_assoc_cache_fifo_tag_model RTL.

module set_assoc_cache_fifo_tag_model_test
    import sacache_pkg::*;
();

    localparam int NUM_WAYS       = 4;
    localparam int NUM_SETS       = 64;
    localparam int SET_BITS       = 6;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 100;
    localparam int STEADY_PHASE   = 4;
    localparam int IDLE_PERCENT   = 26;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
    } access_result_t;

    typedef enum logic {ROW_LOOKUP, ROW_CONFIG} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_SEL_W-1:0] reg_sel;
        logic [CFG_W-1:0]     value;
        logic [ADDR_IN_W-1:0] addr;
        logic                 typed;
        access_result_t       want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_SEL_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [ADDR_IN_W-1:0] s_read_address;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_hit;
    logic [CNT_W-1:0]     m_hit_total;
    logic [CNT_W-1:0]     m_miss_total;

    logic [TAG_W-1:0] way_tag   [NUM_SETS*NUM_WAYS];
    logic             way_valid [NUM_SETS*NUM_WAYS];
    logic [1:0]       fifo_ptr  [NUM_SETS];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [OFF_W-1:0] cfg_offset;
    logic [IDX_W-1:0] cfg_index_bits;

    access_result_t pending_results[$];
    stim_row_t      directed_rows[DIRECTED_ROWS];
    int             error_count = 0;
    int             quiet_cycles = 0;
    bit             steady = 1'b0;

    set_assoc_cache_fifo_tag_model #(
        .WAYS       (NUM_WAYS),
        .SETS       (NUM_SETS),
        .ADDR_WIDTH (ADDR_IN_W)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_read_address (s_read_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_hit_total    (m_hit_total),
        .m_miss_total   (m_miss_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic access_result_t lookup_cache(logic [ADDR_IN_W-1:0] addr);
        logic [IDX_W-1:0]   ib;
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_W-1:0]   tag;
        logic [1:0]         way;
        logic               found;
        ib = (cfg_index_bits > IDX_W'(SET_BITS)) ? IDX_W'(SET_BITS) : cfg_index_bits;
        set_idx = SET_BITS'((addr >> cfg_offset) & ((32'd1 << ib) - 32'd1));
        tag = addr >> (SHIFT_W'(cfg_offset) + SHIFT_W'(ib));
        found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_valid[{set_idx, 2'(w)}] && way_tag[{set_idx, 2'(w)}] == tag) begin
                found = 1'b1;
            end
        end
        if (found) begin
            if (hit_count != CNT_MAX) hit_count++;
        end else begin
            if (miss_count != CNT_MAX) miss_count++;
            way = fifo_ptr[set_idx];
            way_tag[{set_idx, way}] = tag;
            way_valid[{set_idx, way}] = 1'b1;
            fifo_ptr[set_idx] = way + 2'd1;
        end
        return '{found, hit_count, miss_count};
    endfunction

    // Mostly a few tags over a few sets so that hits and FIFO evictions dominate.
    function automatic logic [ADDR_IN_W-1:0] pick_address();
        logic [IDX_W-1:0]     ib;
        logic [ADDR_IN_W-1:0] tag;
        logic [ADDR_IN_W-1:0] set_sel;
        logic [ADDR_IN_W-1:0] low;
        int                   r;
        ib = (cfg_index_bits > IDX_W'(SET_BITS)) ? IDX_W'(SET_BITS) : cfg_index_bits;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        tag = (r < 35) ? ADDR_IN_W'($urandom) : ADDR_IN_W'($urandom_range(0, 7));
        set_sel = ADDR_IN_W'($urandom_range(0, 3)) & ((32'd1 << ib) - 32'd1);
        low = ADDR_IN_W'($urandom) & ((32'd1 << cfg_offset) - 32'd1);
        return (tag << (SHIFT_W'(cfg_offset) + SHIFT_W'(ib))) | (set_sel << cfg_offset) | low;
    endfunction

    task automatic push_address(input logic [ADDR_IN_W-1:0] addr, input logic typed,
                                input access_result_t typed_result);
        access_result_t predicted;
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_read_address = addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = lookup_cache(addr);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_SEL_W-1:0] sel, input logic [CFG_W-1:0] value);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_index = sel;
        cfg_wr_data = value;
        if (sel == REG_OFFSET_BITS) cfg_offset = value[OFF_W-1:0];
        else if (sel == REG_INDEX_BITS) cfg_index_bits = value[IDX_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin : check_results
        access_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no lookup pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, m_hit);
                    error_count++;
                end
                if (m_hit_total !== want.hit_total) begin
                    $error("hit_total: expected %0d, actual %0d", want.hit_total, m_hit_total);
                    error_count++;
                end
                if (m_miss_total !== want.miss_total) begin
                    $error("miss_total: expected %0d, actual %0d", want.miss_total, m_miss_total);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [OFF_W-1:0] phase_offset;
        logic [CFG_W-1:0] phase_index;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_OFFSET_BITS;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_read_address = '0;
        for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
            way_tag[i] = '0;
            way_valid[i] = 1'b0;
        end
        for (int i = 0; i < NUM_SETS; i++) fifo_ptr[i] = '0;
        hit_count = '0;
        miss_count = '0;
        cfg_offset = OFFSET_BITS_RST;
        cfg_index_bits = INDEX_BITS_RST;

        directed_rows = '{
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 32'd1}},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'd1, 32'd1}},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'hFFFF_FFC0, 1'b1, '{1'b1, 32'd2, 32'd1}},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_0000, 1'b1, '{1'b0, 32'd2, 32'd2}},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_003F, 1'b1, '{1'b1, 32'd3, 32'd2}},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_0140, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_1140, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_2140, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_3140, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_4140, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_0140, 1'b0, '0},
            '{ROW_CONFIG, REG_OFFSET_BITS, 4'd0,  32'h0000_0000, 1'b0, '0},
            '{ROW_CONFIG, REG_INDEX_BITS,  4'd0,  32'h0000_0000, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h0000_0000, 1'b0, '0},
            '{ROW_CONFIG, REG_OFFSET_BITS, 4'd15, 32'h0000_0000, 1'b0, '0},
            '{ROW_CONFIG, REG_INDEX_BITS,  4'd15, 32'h0000_0000, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h8000_0000, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h7FFF_8000, 1'b0, '0},
            '{ROW_CONFIG, REG_OFFSET_BITS, 4'd12, 32'h0000_0000, 1'b0, '0},
            '{ROW_CONFIG, REG_INDEX_BITS,  4'd3,  32'h0000_0000, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h1234_5678, 1'b0, '0},
            '{ROW_LOOKUP, REG_OFFSET_BITS, 4'd0,  32'h1234_5678, 1'b0, '0}
        };

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                write_register(directed_rows[i].reg_sel, directed_rows[i].value);
            end else begin
                push_address(directed_rows[i].addr, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    phase_offset = 4'd0;
                    phase_index = 4'd0;
                end
                1: begin
                    phase_offset = 4'd15;
                    phase_index = 4'd15;
                end
                2: begin
                    phase_offset = OFFSET_BITS_RST;
                    phase_index = CFG_W'(INDEX_BITS_RST);
                end
                default: begin
                    phase_offset = OFF_W'($urandom_range(0, 15));
                    phase_index = CFG_W'($urandom_range(0, 15));
                end
            endcase
            write_register(REG_OFFSET_BITS, phase_offset);
            write_register(REG_INDEX_BITS, phase_index);
            steady = (p == STEADY_PHASE);
            repeat (PHASE_ITEMS) push_address(pick_address(), 1'b0, '0);
            steady = 1'b0;
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("lookups left without a result: %0d", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
